@@ design/vfh_pkg.sv @@
// Package for the varint frame header parser.
// Holds the phase and status codes, the result item type and sizing constants.
package vfh_pkg;

    localparam int unsigned SEQ_W   = 64;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned COUNT_W = 33;
    localparam int unsigned VCNT_W  = 4;

    // Ten bytes carry 64 bits; an eleventh byte is an overlong varint
    localparam logic [VCNT_W-1:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SIZE_W-1:0] MAX_RAW_SIZE_RST = 32'd1048576;

    // Register byte addresses, decoded on the word address bit
    localparam logic ADDR_MAX_RAW_SIZE = 1'b0;

    typedef enum logic [2:0] {
        PH_SEQ     = 3'd0,
        PH_CODEC   = 3'd1,
        PH_SIZE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DROP    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_PROTO = 2'd2,
        ST_LIMIT = 2'd3
    } status_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [7:0] CODEC_RAW        = 8'd0;
    localparam logic [7:0] CODEC_COMPRESSED = 8'd1;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data;
        logic              comp;
        status_t           status;
        logic [SEQ_W-1:0]  seq;
        logic [SIZE_W-1:0] size;
        logic              last;
    } result_t;

endpackage

@@ design/varint_frame_header_parser_core.sv @@
// Top level of the varint frame header parser: byte stream in, payload beats and
// end-of-frame reports out, APB register for the raw size limit.
// Depends on vfh_pkg.
//
// Usage:
//   s_axis carries one frame byte per beat in tdata[7:0]; tlast marks the last
//   byte of a frame. m_axis carries result beats: payload bytes of the frame,
//   tagged raw or compressed, and one report beat per frame with status,
//   sequence number and declared raw size. tlast on m_axis marks the last beat
//   caused by one input byte.
//   A result is registered and appears on m_axis in the cycle after its input beat.
//   Throughput: one byte per cycle while m_axis takes every beat. A frame's last
//   payload byte produces two beats (payload and report); s_axis_tready drops
//   while the second of them waits in the queue.
//   The header is decoded by a per-byte state machine with a 64-bit varint
//   accumulator; the output side is a two-beat queue, and s_axis_tready is high
//   when that queue will be empty after the current output transfer.
//   When m_axis stalls, at most two beats wait in the queue and s_axis_tready
//   stays low until the receiver takes them.
//   Reset (aresetn low, synchronous) clears the frame state and the queue and
//   sets max_raw_size to 1048576. Write max_raw_size at byte address 0 only
//   while the block is idle.
//   Payload beats of a frame whose report status is not ok must be discarded.
module varint_frame_header_parser_core (
    input  logic         aclk,
    input  logic         aresetn,
    // APB register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // frame byte input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] frame_byte
    input  logic         s_axis_tlast,   // frame_end
    // result output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                         // [73:10] frame_sequence,
                                         // [105:74] declared_size, [111:106] zero
    output logic [1:0]   m_axis_tuser,   // [0] item_kind, [1] is_compressed
    output logic         m_axis_tlast    // last_of_run
);
    import vfh_pkg::*;

    logic [SIZE_W-1:0]  max_reg;

    phase_t             phase_reg, phase_next;
    logic [VCNT_W-1:0]  cnt_reg, cnt_next;
    logic [SEQ_W-1:0]   acc_reg, acc_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [7:0]         codec_reg, codec_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            err_reg, err_next;

    result_t            slot0_reg, slot1_reg;
    logic               v0_reg, v1_reg;

    logic               s_accept, m_pop, cfg_wr;
    logic [6:0]         shamt;
    logic [SEQ_W-1:0]   acc_or;
    logic               has_payload;
    status_t            final_status;
    result_t            pay_item, rep_item;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == ADDR_MAX_RAW_SIZE) ? max_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_RAW_SIZE_RST;
        end else if (cfg_wr && paddr[2] == ADDR_MAX_RAW_SIZE) begin
            max_reg <= pwdata;
        end
    end

    // ---------------- handshakes ----------------
    assign m_pop         = v0_reg && m_axis_tready;
    assign s_axis_tready = !v1_reg && (!v0_reg || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------- header decode ----------------
    // byte k of a varint lands at bit 7*k
    assign shamt  = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
    assign acc_or = acc_reg | ({{(SEQ_W-7){1'b0}}, s_axis_tdata[6:0]} << shamt);

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        seq_next     = seq_reg;
        codec_next   = codec_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        has_payload  = 1'b0;
        final_status = ST_OK;

        unique case (phase_reg)
            PH_SEQ: begin
                if (cnt_reg == VARINT_MAX_BYTES) begin
                    err_next   = ST_PROTO;
                    phase_next = PH_DROP;
                end else if (!s_axis_tdata[7]) begin
                    seq_next   = acc_or;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PH_CODEC;
                end else begin
                    acc_next = acc_or;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_CODEC: begin
                codec_next = s_axis_tdata;
                phase_next = PH_SIZE;
            end
            PH_SIZE: begin
                if (cnt_reg == VARINT_MAX_BYTES) begin
                    err_next   = ST_PROTO;
                    phase_next = PH_DROP;
                end else if (!s_axis_tdata[7]) begin
                    size_next = acc_or[SIZE_W-1:0];
                    acc_next  = '0;
                    cnt_next  = '0;
                    // limit check goes before the codec check
                    if (acc_or[SEQ_W-1:SIZE_W] != '0 || acc_or[SIZE_W-1:0] > max_reg) begin
                        err_next   = ST_LIMIT;
                        phase_next = PH_DROP;
                    end else if (codec_reg > CODEC_COMPRESSED) begin
                        err_next   = ST_PROTO;
                        phase_next = PH_DROP;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end else begin
                    acc_next = acc_or;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            PH_PAYLOAD: begin
                has_payload = 1'b1;
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
            end
            default: begin
                // dropping until frame end
            end
        endcase

        final_status = err_next;
        if (err_next == ST_OK) begin
            if (phase_next != PH_PAYLOAD) begin
                final_status = ST_TRUNC;
            end else if (codec_next == CODEC_RAW && count_next != {1'b0, size_next}) begin
                final_status = ST_PROTO;
            end
        end

        pay_item.kind   = KIND_PAYLOAD;
        pay_item.data   = s_axis_tdata;
        pay_item.comp   = (codec_reg == CODEC_COMPRESSED);
        pay_item.status = ST_OK;
        pay_item.seq    = '0;
        pay_item.size   = '0;
        pay_item.last   = !s_axis_tlast;

        rep_item.kind   = KIND_REPORT;
        rep_item.data   = '0;
        rep_item.comp   = (codec_next == CODEC_COMPRESSED);
        rep_item.status = final_status;
        rep_item.seq    = seq_next;
        rep_item.size   = (final_status == ST_OK) ? size_next : '0;
        rep_item.last   = 1'b1;

        if (s_axis_tlast) begin
            phase_next = PH_SEQ;
            cnt_next   = '0;
            acc_next   = '0;
            seq_next   = '0;
            codec_next = '0;
            size_next  = '0;
            count_next = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEQ;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            seq_reg   <= '0;
            codec_reg <= '0;
            size_reg  <= '0;
            count_reg <= '0;
            err_reg   <= ST_OK;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            seq_reg   <= seq_next;
            codec_reg <= codec_next;
            size_reg  <= size_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // ---------------- output queue ----------------
    // An input beat is only taken when the queue drains this cycle, so both
    // result beats of one input load straight into the two slots.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (s_accept) begin
            v0_reg <= has_payload || s_axis_tlast;
            v1_reg <= has_payload && s_axis_tlast;
        end else if (m_pop) begin
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            slot0_reg <= has_payload ? pay_item : rep_item;
            slot1_reg <= rep_item;
        end else if (m_pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    assign m_axis_tvalid = v0_reg;
    assign m_axis_tdata  = {6'b0, slot0_reg.size, slot0_reg.seq, slot0_reg.status,
                            slot0_reg.data};
    assign m_axis_tuser  = {slot0_reg.comp, slot0_reg.kind};
    assign m_axis_tlast  = slot0_reg.last;

    // ---------------- assertions ----------------
    a_queue_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> v0_reg)
        else $error("second queue slot valid while the first is empty");

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !v1_reg)
        else $error("input ready while two beats are queued");

    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("report beat without last mark");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_axis_tlast) |=> (phase_reg == PH_SEQ && err_reg == ST_OK
                                        && count_reg == '0))
        else $error("frame state not cleared after frame end");

endmodule

@@ tb/sv/varint_frame_header_parser_core_tb.sv @@
// Testbench for varint_frame_header_parser_core: directed and random frames in,
// result beats checked field by field against a predictor of the header parser.
// Depends on vfh_pkg and the design top level; needs no files or arguments.
module varint_frame_header_parser_core_tb;
    import vfh_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {
        VI_MORE,
        VI_DONE,
        VI_OVERLONG
    } varint_step_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] frame_byte
    logic         s_axis_tlast;   // frame_end
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // [7:0] payload_byte, [9:8] frame_status,
                                  // [73:10] frame_sequence, [105:74] declared_size
    logic [1:0]   m_axis_tuser;   // [0] item_kind, [1] is_compressed
    logic         m_axis_tlast;   // last_of_run

    // parser state mirrored by the predictor
    phase_t          parse_phase;
    logic [6:0]      vi_shift;
    logic [63:0]     vi_acc;
    logic [63:0]     seq_value;
    logic [7:0]      codec_value;
    logic [63:0]     size_value;
    logic [COUNT_W-1:0] payload_count;
    status_t         frame_error;
    logic [31:0]     size_limit;

    result_t     expected_results[$];
    logic [7:0]  frame_bytes[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_rx = 1'b0;

    varint_frame_header_parser_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off while hold_rx is set
    always @(posedge aclk) begin
        if (hold_rx)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ---------------- predictor ----------------

    function automatic void clear_frame_state();
        parse_phase   = PH_SEQ;
        vi_shift      = '0;
        vi_acc        = '0;
        seq_value     = '0;
        codec_value   = '0;
        size_value    = '0;
        payload_count = '0;
        frame_error   = ST_OK;
    endfunction

    function automatic varint_step_t take_varint_byte(logic [7:0] b);
        if (vi_shift > 7'd63)
            return VI_OVERLONG;
        // only bit 0 of the tenth byte survives the shift
        vi_acc |= {57'd0, b[6:0]} << vi_shift;
        if (!b[7])
            return VI_DONE;
        vi_shift += 7'd7;
        return VI_MORE;
    endfunction

    function automatic void parse_frame_byte(logic [7:0] b, logic fin);
        result_t      beats[$];
        result_t      r;
        varint_step_t vs;
        int           i;
        case (parse_phase)
            PH_SEQ: begin
                vs = take_varint_byte(b);
                if (vs == VI_OVERLONG) begin
                    frame_error = ST_PROTO;
                    parse_phase = PH_DROP;
                end else if (vs == VI_DONE) begin
                    seq_value   = vi_acc;
                    vi_acc      = '0;
                    vi_shift    = '0;
                    parse_phase = PH_CODEC;
                end
            end
            PH_CODEC: begin
                codec_value = b;
                parse_phase = PH_SIZE;
            end
            PH_SIZE: begin
                vs = take_varint_byte(b);
                if (vs == VI_OVERLONG) begin
                    frame_error = ST_PROTO;
                    parse_phase = PH_DROP;
                end else if (vs == VI_DONE) begin
                    size_value = vi_acc;
                    vi_acc     = '0;
                    vi_shift   = '0;
                    // limit check wins over the codec check
                    if (size_value > {32'd0, size_limit}) begin
                        frame_error = ST_LIMIT;
                        parse_phase = PH_DROP;
                    end else if (codec_value > CODEC_COMPRESSED) begin
                        frame_error = ST_PROTO;
                        parse_phase = PH_DROP;
                    end else begin
                        parse_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                r        = '0;
                r.kind   = KIND_PAYLOAD;
                r.data   = b;
                r.comp   = (codec_value == CODEC_COMPRESSED);
                r.status = ST_OK;
                beats.push_back(r);
                if (payload_count != COUNT_MAX)
                    payload_count++;
            end
            default: ;
        endcase
        if (fin) begin
            if (frame_error == ST_OK) begin
                if (parse_phase != PH_PAYLOAD)
                    frame_error = ST_TRUNC;
                else if (codec_value == CODEC_RAW && {31'd0, payload_count} != size_value)
                    frame_error = ST_PROTO;
            end
            r        = '0;
            r.kind   = KIND_REPORT;
            r.comp   = (codec_value == CODEC_COMPRESSED);
            r.status = frame_error;
            r.seq    = seq_value;
            r.size   = (frame_error == ST_OK) ? size_value[31:0] : 32'd0;
            beats.push_back(r);
            clear_frame_state();
        end
        if (beats.size() > 0)
            beats[beats.size() - 1].last = 1'b1;
        for (i = 0; i < beats.size(); i++)
            expected_results.push_back(beats[i]);
    endfunction

    // ---------------- checking ----------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h/%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("item_kind", 64'(want.kind), 64'(m_axis_tuser[0]));
                    check_field("payload_byte", 64'(want.data), 64'(m_axis_tdata[7:0]));
                    check_field("is_compressed", 64'(want.comp), 64'(m_axis_tuser[1]));
                    check_field("frame_status", 64'(want.status), 64'(m_axis_tdata[9:8]));
                    check_field("frame_sequence", want.seq, m_axis_tdata[73:10]);
                    check_field("declared_size", 64'(want.size), 64'(m_axis_tdata[105:74]));
                    check_field("last_of_run", 64'(want.last), 64'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_frame_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // ---------------- drivers ----------------

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    // header bytes give no results, so the wait runs on past the last expected beat
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {ADDR_MAX_RAW_SIZE, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_size_limit_reg(input logic [31:0] want);
        logic [31:0] rd;
        apb_access(1'b0, 32'd0, rd);
        check_field("max_raw_size readback", 64'(want), 64'(rd));
    endtask

    task automatic set_size_limit(input logic [31:0] lim);
        logic [31:0] rd;
        apb_access(1'b1, lim, rd);
        size_limit = lim;
        check_size_limit_reg(lim);
    endtask

    // ---------------- frame building ----------------

    function automatic logic [63:0] random_wide();
        logic [63:0] v;
        int w;
        v = {$urandom, $urandom};
        w = $urandom_range(64, 0);
        if (w < 64)
            v &= (64'd1 << w) - 64'd1;
        return v;
    endfunction

    function automatic int varint_len(logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0)
            n++;
        return n;
    endfunction

    // len above the minimum gives padded groups; 11 or more is overlong
    task automatic append_varint(input logic [63:0] v, input int len);
        logic [63:0] grp;
        int i;
        for (i = 0; i < len; i++) begin
            grp = v >> (7 * i);
            frame_bytes.push_back({i != len - 1, grp[6:0]});
        end
    endtask

    task automatic send_random_frame();
        logic [63:0] seq_v;
        logic [63:0] size_v;
        logic [7:0]  codec_v;
        logic [7:0]  b;
        int pick, sel, n, hdr_len, plen, cut, i;
        pick = $urandom_range(99);
        if (pick < 5) begin
            // noise
            n = $urandom_range(6, 1);
            for (i = 0; i < n; i++)
                frame_bytes.push_back(8'($urandom));
        end else begin
            seq_v = random_wide();
            n = varint_len(seq_v);
            if ($urandom_range(7) == 0)
                n = 10;
            else if ($urandom_range(7) == 0 && n < 10)
                n++;
            if (pick < 10)
                n = 11 + $urandom_range(2);
            append_varint(seq_v, n);
            if (n == 10 && $urandom_range(1)) begin
                // junk above bit 0 of the tenth byte is dropped
                b = frame_bytes.pop_back();
                b[6:1] = 6'($urandom);
                frame_bytes.push_back(b);
            end
            sel = $urandom_range(19);
            if (sel < 9)
                codec_v = CODEC_RAW;
            else if (sel < 18)
                codec_v = CODEC_COMPRESSED;
            else
                codec_v = 8'($urandom);
            frame_bytes.push_back(codec_v);
            sel = $urandom_range(9);
            if (sel < 6)
                size_v = 64'($urandom_range(8));
            else if (sel < 8)
                size_v = {32'd0, size_limit} + 64'($urandom_range(1));
            else
                size_v = random_wide();
            n = varint_len(size_v);
            if ($urandom_range(7) == 0 && n < 10)
                n++;
            if (pick >= 10 && pick < 15)
                n = 11;
            append_varint(size_v, n);
            hdr_len = frame_bytes.size();
            if (codec_v == CODEC_RAW && size_v <= 64'd8) begin
                sel  = $urandom_range(5);
                plen = int'(size_v);
                if (sel == 0)
                    plen++;
                else if (sel == 1 && plen > 0)
                    plen--;
            end else begin
                plen = $urandom_range(8);
            end
            if (pick >= 15 && pick < 30) begin
                // frame ends inside the header
                cut = $urandom_range(hdr_len - 1, 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end else begin
                for (i = 0; i < plen; i++)
                    frame_bytes.push_back(8'($urandom));
            end
        end
        send_frame();
    endtask

    // ---------------- tests ----------------

    task automatic test_register_reset();
        check_size_limit_reg(MAX_RAW_SIZE_RST);
    endtask

    task automatic test_directed_frames();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // ends right after the sequence: truncated
        frame_bytes = '{8'h00};
        send_frame();
        // good raw frame, one payload byte
        frame_bytes = '{8'h7f, CODEC_RAW, 8'h01, 8'hff};
        send_frame();
        // compressed, count not checked against size
        frame_bytes = '{8'h80, 8'h01, CODEC_COMPRESSED, 8'h00, 8'ha5, 8'h5a};
        send_frame();
        // unknown codec
        frame_bytes = '{8'h00, 8'hff, 8'h00};
        send_frame();
        // raw length mismatch
        frame_bytes = '{8'h00, CODEC_RAW, 8'h02, 8'h11};
        send_frame();
        // size 1048577 over the limit, with a bad codec: limit error wins
        frame_bytes = '{8'h01, 8'h02, 8'h81, 8'h80, 8'h40, 8'h33};
        send_frame();
        // empty raw payload, frame ends on the size byte
        frame_bytes = '{8'h00, CODEC_RAW, 8'h00};
        send_frame();
        wait_drain();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [31:0] lim, input int n_items);
        int stop_at;
        set_size_limit(lim);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
            send_random_frame();
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        int f, i;
        set_size_limit(32'd64);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                hold_rx = 1'b1;
                repeat (150) @(posedge aclk);
                hold_rx = 1'b0;
            end
        join_none
        for (f = 0; f < 3; f++) begin
            append_varint(random_wide(), 3);
            frame_bytes.push_back(f == 1 ? CODEC_RAW : CODEC_COMPRESSED);
            frame_bytes.push_back(8'd20);
            for (i = 0; i < 20; i++)
                frame_bytes.push_back(8'($urandom));
            send_frame();
        end
        wait_drain();
    endtask

    initial begin
        size_limit = MAX_RAW_SIZE_RST;
        clear_frame_state();
        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_reset();
        test_directed_frames();
        test_random_traffic(17, 57, 32'd0, 300);
        test_output_backpressure();
        test_random_traffic(57, 17, 32'hffff_ffff, 320);
        test_random_traffic(0, 0, MAX_RAW_SIZE_RST, 320);

        wait_drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
